// ===== sv/rpd_pkg.sv =====
// rpd_pkg: shared types, constants and the sample decode function of the
// readout packet deframer; no dependencies
`default_nettype none

package rpd_pkg;

  localparam int unsigned DEF_NUM_ASICS   = 10;
  localparam int unsigned DEF_NUM_SAMPLES = 64;
  localparam int unsigned DEF_NUM_WINDOWS = 512;

  localparam int unsigned RES_DEPTH = 4;

  localparam logic [31:0] SYNC_WORD     = 32'h00be11e2;
  localparam logic [31:0] TYPE_WORD     = 32'h00000013;
  localparam logic [31:0] EVNT_TAG      = 32'h65766e74;
  localparam logic [7:0]  WIN_PREFIX    = 8'hFE;
  localparam logic [7:0]  SAMPLE_PREFIX = 8'hBD;

  localparam logic [31:0] RST_BOARD_ID       = 32'h00a3002c;
  localparam logic [31:0] RST_FORMAT_VERSION = 32'h20121128;

  localparam logic [1:0] CFG_DECODE_GRAY    = 2'd0;
  localparam logic [1:0] CFG_BOARD_ID       = 2'd1;
  localparam logic [1:0] CFG_FORMAT_VERSION = 2'd2;

  localparam logic [1:0] KIND_SAMPLE  = 2'd0;
  localparam logic [1:0] KIND_INVALID = 2'd1;
  localparam logic [1:0] KIND_CLOSE   = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic        last;
    logic [31:0] event_number;
    logic        event_known;
    logic [3:0]  asic_field;
    logic [3:0]  channel;
    logic [1:0]  window_in_group;
    logic [6:0]  sample_index;
    logic [11:0] sample_value;
    logic [8:0]  dig_window;
    logic [8:0]  write_window;
  } result_t;

  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic logic [11:0] gray_decode(input logic [11:0] v);
    logic [11:0] res;
    logic        b;
    b       = ~v[11];
    res     = '0;
    res[11] = b;
    for (int k = 10; k >= 1; k--) begin
      b      = b ^ ~(v[k+1] ^ v[k]);
      res[k] = b;
    end
    res[0] = ~v[0];
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== sv/rpd_core.sv =====
// rpd_core: header matching, window/event state and result building for one
// accepted beat per cycle; depends on rpd_pkg
`default_nettype none

module rpd_core
  import rpd_pkg::*;
#(
  parameter int unsigned NUM_ASICS   = DEF_NUM_ASICS,
  parameter int unsigned NUM_SAMPLES = DEF_NUM_SAMPLES,
  parameter int unsigned NUM_WINDOWS = DEF_NUM_WINDOWS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        accept_i,
  input  wire logic        cmd_i,
  input  wire logic [31:0] word_i,
  output push_t            push_o
);

  typedef enum logic [2:0] {
    HUNT, GOT_SYNC, GOT_TYPE, GOT_TAG, GOT_BOARD, GOT_VER, GOT_W5, GOT_W6
  } mpos_e;

  mpos_e       mpos_q, mpos_d;
  logic        body_q, body_d;
  logic [31:0] h5_q, h5_d, h6_q, h6_d;
  logic [31:0] ev_q, ev_d;
  logic        seen_q, seen_d;
  logic [8:0]  dig_q, dig_d, wr_q, wr_d;
  logic [3:0]  asic_q, asic_d;
  logic        gray_q;
  logic [31:0] board_q, ver_q;
  push_t       push;

  function automatic result_t mk_close(input logic [31:0] ev, input logic seen);
    result_t r;
    r              = '0;
    r.kind         = KIND_CLOSE;
    r.event_number = ev;
    r.event_known  = seen;
    return r;
  endfunction

  function automatic result_t mk_sample(input logic [31:0] w, input logic [8:0] dig,
                                        input logic [8:0] wr, input logic [3:0] asic,
                                        input logic [31:0] ev, input logic seen,
                                        input logic gray);
    result_t r;
    logic    ok;
    r                 = '0;
    ok = ({1'b0, dig} < 10'(NUM_WINDOWS)) && (asic != 4'd0) &&
         ({1'b0, asic - 4'd1} <= 5'(NUM_ASICS)) &&
         ({1'b0, w[18:12]} < 8'(NUM_SAMPLES));
    r.kind            = ok ? KIND_SAMPLE : KIND_INVALID;
    r.event_number    = ev;
    r.event_known     = seen;
    r.asic_field      = asic;
    r.channel         = w[22:19];
    r.window_in_group = w[18:17];
    r.sample_index    = w[18:12];
    r.sample_value    = gray ? gray_decode(w[11:0]) : w[11:0];
    r.dig_window      = dig;
    r.write_window    = wr;
    return r;
  endfunction

  function automatic mpos_e restart(input logic [31:0] w);
    return (w == SYNC_WORD) ? GOT_SYNC : HUNT;
  endfunction

  always_comb begin
    mpos_d   = mpos_q;
    body_d   = body_q;
    h5_d     = h5_q;
    h6_d     = h6_q;
    ev_d     = ev_q;
    seen_d   = seen_q;
    dig_d    = dig_q;
    wr_d     = wr_q;
    asic_d   = asic_q;
    push.cnt = 2'd0;
    push.r0  = mk_close(ev_q, seen_q);
    push.r1  = mk_close(ev_q, seen_q);
    if (cmd_i) begin
      mpos_d   = HUNT;
      body_d   = 1'b0;
      push.cnt = 2'd1;
    end else if (body_q && word_i[31:24] == SAMPLE_PREFIX) begin
      push.r0  = mk_sample(word_i, dig_q, wr_q, asic_q, ev_q, seen_q, gray_q);
      push.cnt = 2'd1;
    end else begin
      body_d = 1'b0;
      unique case (body_q ? HUNT : mpos_q)
        HUNT:      mpos_d = restart(word_i);
        GOT_SYNC:  mpos_d = (word_i == TYPE_WORD) ? GOT_TYPE : restart(word_i);
        GOT_TYPE:  mpos_d = (word_i == EVNT_TAG) ? GOT_TAG : restart(word_i);
        GOT_TAG:   mpos_d = (word_i == board_q) ? GOT_BOARD : restart(word_i);
        GOT_BOARD: mpos_d = (word_i == ver_q) ? GOT_VER : restart(word_i);
        GOT_VER: begin
          h5_d   = word_i;
          mpos_d = GOT_W5;
        end
        GOT_W5: begin
          h6_d   = word_i;
          mpos_d = GOT_W6;
        end
        GOT_W6: begin
          mpos_d = HUNT;
          if (word_i == EVNT_TAG) begin
            if (!seen_q) begin
              seen_d = 1'b1;
              ev_d   = h5_q;
            end else if (h5_q != ev_q) begin
              push.cnt = 2'd1;
              ev_d     = h5_q;
            end
          end else if (h5_q[31:24] == WIN_PREFIX) begin
            dig_d  = h5_q[8:0];
            wr_d   = h5_q[17:9];
            asic_d = h5_q[23:20];
            if (h6_q[31:24] == SAMPLE_PREFIX) begin
              push.r0 = mk_sample(h6_q, h5_q[8:0], h5_q[17:9], h5_q[23:20],
                                  ev_q, seen_q, gray_q);
              if (word_i[31:24] == SAMPLE_PREFIX) begin
                push.r1  = mk_sample(word_i, h5_q[8:0], h5_q[17:9], h5_q[23:20],
                                     ev_q, seen_q, gray_q);
                push.cnt = 2'd2;
                body_d   = 1'b1;
              end else begin
                push.cnt = 2'd1;
                mpos_d   = restart(word_i);
              end
            end else begin
              mpos_d = restart(word_i);
            end
          end else begin
            mpos_d = restart(word_i);
          end
        end
        default: mpos_d = HUNT;
      endcase
    end
    push.r0.last = (push.cnt == 2'd1);
    push.r1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mpos_q  <= HUNT;
      body_q  <= 1'b0;
      ev_q    <= '0;
      seen_q  <= 1'b0;
      dig_q   <= '0;
      wr_q    <= '0;
      asic_q  <= '0;
      gray_q  <= 1'b0;
      board_q <= RST_BOARD_ID;
      ver_q   <= RST_FORMAT_VERSION;
    end else begin
      if (accept_i) begin
        mpos_q <= mpos_d;
        body_q <= body_d;
        ev_q   <= ev_d;
        seen_q <= seen_d;
        dig_q  <= dig_d;
        wr_q   <= wr_d;
        asic_q <= asic_d;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_DECODE_GRAY:    gray_q  <= cfg_data_i[0];
          CFG_BOARD_ID:       board_q <= cfg_data_i;
          CFG_FORMAT_VERSION: ver_q   <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // held header words
  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      h5_q <= h5_d;
      h6_q <= h6_d;
    end
  end

  assign push_o = accept_i ? push : '{cnt: 2'd0, r0: push.r0, r1: push.r1};

endmodule

`default_nettype wire

// ===== sv/rpd_fifo.sv =====
// rpd_fifo: small result queue taking up to two results per cycle and
// handing out one per beat; depends on rpd_pkg
`default_nettype none

module rpd_fifo
  import rpd_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire push_t   push_i,
  output logic         full_o,
  output logic         valid_o,
  input  wire logic    pop_i,
  output result_t      data_o
);

  localparam int unsigned AW = $clog2(RES_DEPTH);
  localparam int unsigned CW = $clog2(RES_DEPTH + 1);

  result_t         mem_q [RES_DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [CW-1:0]   count_q;
  logic            pop;

  assign valid_o = (count_q != '0);
  assign pop     = pop_i && valid_o;
  assign full_o  = (count_q > CW'(RES_DEPTH - 2));
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + AW'(push_i.cnt);
      rptr_q  <= rptr_q + AW'(pop);
      count_q <= count_q + CW'(push_i.cnt) - CW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wptr_q + AW'(1)] <= push_i.r1;
    end
  end

endmodule

`default_nettype wire

// ===== sv/readout_packet_deframer.sv =====
// readout_packet_deframer: top level of the readout stream deframer
// depends on rpd_pkg, rpd_core and rpd_fifo
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    cmd, word
//  out      source     out_valid/out_stall  kind, last, event and sample fields
//  cfg      sink       cfg_valid/cfg_ready  index, data
//
// one input beat per cycle while in_stall is low; each beat is decoded in the cycle it is taken
// results are queued in a four-entry buffer and leave one per beat
// a beat that yields two results hands them out one after the other
// in_stall rises only when fewer than two queue entries are free
// reset returns framing to hunting and clears the event state
`default_nettype none

module readout_packet_deframer
  import rpd_pkg::*;
#(
  parameter int unsigned NUM_ASICS   = DEF_NUM_ASICS,
  parameter int unsigned NUM_SAMPLES = DEF_NUM_SAMPLES,
  parameter int unsigned NUM_WINDOWS = DEF_NUM_WINDOWS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        in_cmd_i,
  input  wire logic [31:0] in_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [1:0]       out_kind_o,
  output logic             out_last_o,
  output logic [31:0]      out_event_number_o,
  output logic             out_event_known_o,
  output logic [3:0]       out_asic_field_o,
  output logic [3:0]       out_channel_o,
  output logic [1:0]       out_window_in_group_o,
  output logic [6:0]       out_sample_index_o,
  output logic [11:0]      out_sample_value_o,
  output logic [8:0]       out_dig_window_o,
  output logic [8:0]       out_write_window_o
);

  push_t   push;
  result_t res;
  logic    full;
  logic    accept;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = full;
  assign accept      = in_valid_i && !full;

  rpd_core #(
    .NUM_ASICS   (NUM_ASICS),
    .NUM_SAMPLES (NUM_SAMPLES),
    .NUM_WINDOWS (NUM_WINDOWS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .cmd_i       (in_cmd_i),
    .word_i      (in_word_i),
    .push_o      (push)
  );

  rpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .valid_o (out_valid_o),
    .pop_i   (!out_stall_i),
    .data_o  (res)
  );

  assign out_kind_o            = res.kind;
  assign out_last_o            = res.last;
  assign out_event_number_o    = res.event_number;
  assign out_event_known_o     = res.event_known;
  assign out_asic_field_o      = res.asic_field;
  assign out_channel_o         = res.channel;
  assign out_window_in_group_o = res.window_in_group;
  assign out_sample_index_o    = res.sample_index;
  assign out_sample_value_o    = res.sample_value;
  assign out_dig_window_o      = res.dig_window;
  assign out_write_window_o    = res.write_window;

endmodule

`default_nettype wire
